FILE: rtl/ain_pkg.sv
package ain_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_W       = 7;
    localparam int CNT_W       = 16;
    localparam int EPS_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Shared divider and root sizes
    localparam int DIVN_W      = 64;
    localparam int DEN_W       = 34;
    localparam int STEP_W      = 6;
    localparam int ROOT_W      = 64;
    localparam int INV_W       = 32;

    // Unity scale in Q4.12
    localparam logic signed [SAMPLE_BITS-1:0] ONE_Q12 = 16'sd4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd3;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_RECIP
    } div_op_t;

    typedef struct packed {
        logic    div_start;
        div_op_t div_op;
        logic    sq_start;
        logic    root_start;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic div_busy;
        logic sq_busy;
        logic root_busy;
        logic out_free;
        logic emit_last;
    } status_t;

endpackage

FILE: rtl/ain_ram.sv
module ain_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one registered word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ain_ctrl.sv
module ain_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  ain_pkg::status_t stat,
    output ain_pkg::cmd_t    cmd,
    output logic             in_stall
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_MEAN,
        S_MEAN_W,
        S_SQ,
        S_SQ_W,
        S_VAR,
        S_VAR_W,
        S_RCP,
        S_RCP_W,
        S_ROOT,
        S_ROOT_W,
        S_RD,
        S_MUL,
        S_MUL2,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take words only while loading
    assign in_stall = (state_reg != S_LOAD);

    // Decode commands and next state
    always_comb
    begin
        state_next     = state_reg;
        cmd.div_start  = 1'b0;
        cmd.div_op     = ain_pkg::DIV_MEAN;
        cmd.sq_start   = 1'b0;
        cmd.root_start = 1'b0;
        cmd.out_load   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid && stat.close)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = ain_pkg::DIV_MEAN;
                state_next    = S_MEAN_W;
            end
            S_MEAN_W:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.sq_start = 1'b1;
                state_next   = S_SQ_W;
            end
            S_SQ_W:
            begin
                if (!stat.sq_busy)
                begin
                    state_next = S_VAR;
                end
            end
            S_VAR:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = ain_pkg::DIV_VAR;
                state_next    = S_VAR_W;
            end
            S_VAR_W:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_RCP;
                end
            end
            S_RCP:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = ain_pkg::DIV_RECIP;
                state_next    = S_RCP_W;
            end
            S_RCP_W:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                cmd.root_start = 1'b1;
                state_next     = S_ROOT_W;
            end
            S_ROOT_W:
            begin
                if (!stat.root_busy)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_MUL2;
            S_MUL2: state_next = S_OUT;
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = stat.emit_last ? S_LOAD : S_RD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/ain_dp.sv
module ain_dp #(
    parameter int MAX_LENGTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ain_pkg::cmd_t                         cmd,
    output ain_pkg::status_t                      stat,
    input  logic                                  in_accept,
    input  logic signed [ain_pkg::SAMPLE_BITS-1:0] sample,
    input  logic signed [ain_pkg::SAMPLE_BITS-1:0] style_scale,
    input  logic signed [ain_pkg::SAMPLE_BITS-1:0] style_shift,
    input  logic                                  mode,
    input  logic [ain_pkg::LEN_W-1:0]             length,
    input  logic [ain_pkg::CNT_W-1:0]             count,
    input  logic [ain_pkg::EPS_W-1:0]             epsilon,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic signed [ain_pkg::SAMPLE_BITS-1:0] value,
    output logic                                  last_of_channel,
    output logic                                  last_of_tensor
);

    localparam int SB     = ain_pkg::SAMPLE_BITS;
    localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int FILL_W = $clog2(MAX_LENGTH + 1);
    localparam int EFF_W  = (FILL_W > ain_pkg::LEN_W) ? FILL_W + 1 : ain_pkg::LEN_W + 1;
    localparam int SUM_W  = SB + ADDR_W + 1;
    localparam int T_W    = SUM_W + 2;
    localparam int D_W    = SB + 1;
    localparam int DD_W   = 2 * SB;
    localparam int SQ_W   = DD_W + ADDR_W + 1;
    localparam int DN_W   = ain_pkg::DIVN_W;
    localparam int DE_W   = ain_pkg::DEN_W;
    localparam int RT_W   = ain_pkg::ROOT_W;
    localparam int IV_W   = ain_pkg::INV_W;
    localparam int P1_W   = D_W + IV_W + 1;
    localparam int Z_W    = P1_W - 12;
    localparam int P2_W   = Z_W + SB;
    localparam int Y_W    = P2_W + 2;

    // Saturation limits of the output word
    localparam logic signed [Y_W-20:0] Y_HI = (Y_W - 19)'((1 <<< (SB - 1)) - 1);
    localparam logic signed [Y_W-20:0] Y_LO = (Y_W - 19)'(-(1 <<< (SB - 1)));

    // Channel load state
    logic [FILL_W-1:0]            fill_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [SB-1:0]         scale_reg;
    logic signed [SB-1:0]         shift_reg;
    logic [ain_pkg::CNT_W-1:0]    chan_reg;

    // Statistics
    logic signed [SB-1:0]         mean_reg;
    logic [SQ_W-1:0]              sq_reg;
    logic [DE_W-1:0]              bigv_reg;
    logic [IV_W-1:0]              inv_reg;

    // Square pass pipeline
    logic                         sq_run_reg;
    logic [ADDR_W-1:0]            sq_idx_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic [DD_W-1:0]              dd_reg;

    // Divider
    logic                         div_run_reg;
    ain_pkg::div_op_t             div_op_reg;
    logic                         neg_reg;
    logic [DN_W-1:0]              num_reg;
    logic [DE_W-1:0]              rem_reg;
    logic [DE_W-1:0]              den_reg;
    logic [ain_pkg::STEP_W-1:0]   step_reg;

    // Root
    logic                         root_run_reg;
    logic [RT_W-1:0]              rv_reg;
    logic [RT_W-1:0]              rr_reg;
    logic [RT_W-1:0]              rbit_reg;

    // Emit pipeline and output word
    logic [ADDR_W-1:0]            e_idx_reg;
    logic signed [P1_W-1:0]       p1_reg;
    logic signed [P2_W-1:0]       p2_reg;
    logic                         out_valid_reg;
    logic signed [SB-1:0]         value_reg;
    logic                         loc_reg;
    logic                         lot_reg;

    logic [ADDR_W-1:0]            raddr;
    logic [SB-1:0]                rdata;
    logic signed [D_W-1:0]        d;
    logic signed [DD_W+1:0]       dd_full;
    logic [EFF_W-1:0]             eff_len;
    logic [ain_pkg::CNT_W-1:0]    cnt_eff;
    logic                         tensor_end;
    logic                         emit_last;
    logic                         sq_last;
    logic signed [T_W-1:0]        mean_t;
    logic [T_W-1:0]               mean_mag;
    logic [DE_W:0]                trial;
    logic                         qbit;
    logic [DN_W-1:0]              quot;
    logic [RT_W-1:0]              rsum;
    logic                         rge;
    logic [RT_W-1:0]              rr_next;
    logic signed [P1_W-1:0]       p1_next;
    logic signed [Z_W-1:0]        z;
    logic signed [P2_W-1:0]       p2_next;
    logic signed [SB-1:0]         sc;
    logic signed [SB-1:0]         sh;
    logic signed [Y_W-1:0]        y_sum;
    logic signed [Y_W-20:0]       y;
    logic signed [SB-1:0]         y_sat;

    ain_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_LENGTH)
    ) u_buf (
        .clk   (clk),
        .we    (in_accept),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Clamp length and count
    always_comb
    begin
        priority if (length == '0)
        begin
            eff_len = EFF_W'(1);
        end
        else if (EFF_W'(length) > EFF_W'(MAX_LENGTH))
        begin
            eff_len = EFF_W'(MAX_LENGTH);
        end
        else
        begin
            eff_len = EFF_W'(length);
        end
    end

    assign cnt_eff    = (count == '0) ? ain_pkg::CNT_W'(1) : count;
    assign tensor_end = ({1'b0, chan_reg} + 1'b1) >= {1'b0, cnt_eff};
    assign emit_last  = (FILL_W'(e_idx_reg) + 1'b1) == fill_reg;
    assign sq_last    = (FILL_W'(sq_idx_reg) + 1'b1) == fill_reg;
    assign raddr      = sq_run_reg ? sq_idx_reg : e_idx_reg;
    assign d          = D_W'($signed(rdata)) - D_W'(mean_reg);
    assign dd_full    = d * d;

    // Divider numerator for the rounded mean
    assign mean_t   = (T_W'(sum_reg) <<< 1) + $signed(T_W'(fill_reg));
    assign mean_mag = mean_t[T_W-1]
                    ? T_W'(-mean_t + $signed(T_W'({fill_reg, 1'b0})) - T_W'(1))
                    : T_W'(mean_t);

    // One restoring divide step
    assign trial = {rem_reg, num_reg[DN_W-1]};
    assign qbit  = trial >= {1'b0, den_reg};
    assign quot  = {num_reg[DN_W-2:0], qbit};

    // One root step
    assign rsum    = rr_reg + rbit_reg;
    assign rge     = rv_reg >= rsum;
    assign rr_next = rge ? ((rr_reg >> 1) + rbit_reg) : (rr_reg >> 1);

    // Normalise, scale and shift
    assign p1_next = d * $signed({1'b0, inv_reg});
    assign z       = Z_W'((p1_reg + P1_W'(2048)) >>> 12);
    assign sc      = mode ? scale_reg : ain_pkg::ONE_Q12;
    assign sh      = mode ? shift_reg : '0;
    assign p2_next = z * sc;
    assign y_sum   = Y_W'(p2_reg) + (Y_W'(sh) <<< 19) + Y_W'(1 << 18);
    assign y       = y_sum[Y_W-1:19];

    // Saturate to the sample range
    always_comb
    begin
        priority if (y > Y_HI)
        begin
            y_sat = {1'b0, {(SB - 1){1'b1}}};
        end
        else if (y < Y_LO)
        begin
            y_sat = {1'b1, {(SB - 1){1'b0}}};
        end
        else
        begin
            y_sat = y[SB-1:0];
        end
    end

    // Pipeline stages of the emit and square passes, held without reset
    always_ff @(posedge clk)
    begin
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        dd_reg <= dd_full[DD_W-1:0];
    end

    // Load, statistics and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            sum_reg       <= '0;
            scale_reg     <= '0;
            shift_reg     <= '0;
            chan_reg      <= '0;
            mean_reg      <= '0;
            sq_reg        <= '0;
            bigv_reg      <= '0;
            inv_reg       <= '0;
            sq_run_reg    <= 1'b0;
            sq_idx_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            div_run_reg   <= 1'b0;
            div_op_reg    <= ain_pkg::DIV_MEAN;
            neg_reg       <= 1'b0;
            num_reg       <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            step_reg      <= '0;
            root_run_reg  <= 1'b0;
            rv_reg        <= '0;
            rr_reg        <= '0;
            rbit_reg      <= '0;
            e_idx_reg     <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            loc_reg       <= 1'b0;
            lot_reg       <= 1'b0;
        end
        else
        begin
            // Buffer an incoming word
            if (in_accept)
            begin
                fill_reg  <= fill_reg + 1'b1;
                sum_reg   <= sum_reg + SUM_W'(sample);
                scale_reg <= style_scale;
                shift_reg <= style_shift;
            end

            // Sweep the buffer for the squared deviations
            if (cmd.sq_start)
            begin
                sq_reg     <= '0;
                sq_idx_reg <= '0;
                sq_run_reg <= 1'b1;
            end
            else if (sq_run_reg)
            begin
                sq_idx_reg <= sq_idx_reg + 1'b1;
                if (sq_last)
                begin
                    sq_run_reg <= 1'b0;
                end
            end
            v1_reg <= sq_run_reg;
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                sq_reg <= sq_reg + SQ_W'(dd_reg);
            end

            // Start or advance the divider
            if (cmd.div_start)
            begin
                div_run_reg <= 1'b1;
                div_op_reg  <= cmd.div_op;
                rem_reg     <= '0;
                step_reg    <= '0;
                neg_reg     <= mean_t[T_W-1];
                unique case (cmd.div_op)
                    ain_pkg::DIV_MEAN:
                    begin
                        num_reg <= DN_W'(mean_mag);
                        den_reg <= DE_W'({fill_reg, 1'b0});
                    end
                    ain_pkg::DIV_VAR:
                    begin
                        num_reg <= DN_W'({sq_reg, 1'b0}) + DN_W'(fill_reg);
                        den_reg <= DE_W'({fill_reg, 1'b0});
                    end
                    ain_pkg::DIV_RECIP:
                    begin
                        num_reg <= DN_W'(1) << 62;
                        den_reg <= bigv_reg;
                    end
                    default:
                    begin
                        num_reg <= '0;
                        den_reg <= '0;
                    end
                endcase
            end
            else if (div_run_reg)
            begin
                num_reg  <= quot;
                rem_reg  <= qbit ? DE_W'(trial - {1'b0, den_reg}) : trial[DE_W-1:0];
                step_reg <= step_reg + 1'b1;
                if (step_reg == ain_pkg::STEP_W'(DN_W - 1))
                begin
                    div_run_reg <= 1'b0;
                    unique case (div_op_reg)
                        ain_pkg::DIV_MEAN:
                        begin
                            mean_reg <= neg_reg ? -$signed(quot[SB-1:0])
                                                : $signed(quot[SB-1:0]);
                        end
                        ain_pkg::DIV_VAR:
                        begin
                            bigv_reg <= DE_W'(quot) + DE_W'(epsilon);
                        end
                        ain_pkg::DIV_RECIP:
                        begin
                            rv_reg <= RT_W'(quot);
                        end
                        default:
                        begin
                            mean_reg <= mean_reg;
                        end
                    endcase
                end
            end

            // Start or advance the root, one result bit a step
            if (cmd.root_start)
            begin
                root_run_reg <= 1'b1;
                rr_reg       <= '0;
                rbit_reg     <= RT_W'(1) << 62;
            end
            else if (root_run_reg)
            begin
                rv_reg   <= rge ? (rv_reg - rsum) : rv_reg;
                rr_reg   <= rr_next;
                rbit_reg <= rbit_reg >> 2;
                if (rbit_reg[0])
                begin
                    root_run_reg <= 1'b0;
                    inv_reg      <= (bigv_reg == '0) ? '1 : rr_next[IV_W-1:0];
                end
            end

            // Drop the output word once taken
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Load the next output word; close the channel on its last one
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                value_reg     <= y_sat;
                loc_reg       <= emit_last;
                lot_reg       <= emit_last && tensor_end;
                if (emit_last)
                begin
                    e_idx_reg <= '0;
                    fill_reg  <= '0;
                    sum_reg   <= '0;
                    chan_reg  <= tensor_end ? '0 : chan_reg + 1'b1;
                end
                else
                begin
                    e_idx_reg <= e_idx_reg + 1'b1;
                end
            end
        end
    end

    assign stat.close     = (EFF_W'(fill_reg) + 1'b1) >= eff_len;
    assign stat.div_busy  = div_run_reg;
    assign stat.sq_busy   = sq_run_reg || v1_reg || v2_reg;
    assign stat.root_busy = root_run_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.emit_last = emit_last;

    assign out_valid       = out_valid_reg;
    assign value           = value_reg;
    assign last_of_channel = loc_reg;
    assign last_of_tensor  = lot_reg;

endmodule

FILE: rtl/adaptive_instance_normalization.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    sample, style_scale, style_shift
// output    out_valid / out_stall  value, last_of_channel, last_of_tensor
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A channel of n samples loads at one word per cycle, then the shared bit-serial
// divider forms the mean, the squared-deviation sweep runs, the same divider forms
// the variance and the reciprocal, and the root is taken; each result then passes
// through the two multiplier stages.
// Reset clears all control state; the sample buffer needs no clearing pass.
// A stalled output word holds in its register while the next result is formed.
module adaptive_instance_normalization #(
    parameter int MAX_LENGTH = 64
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [ain_pkg::SAMPLE_BITS-1:0]   sample,
    input  logic signed [ain_pkg::SAMPLE_BITS-1:0]   style_scale,
    input  logic signed [ain_pkg::SAMPLE_BITS-1:0]   style_shift,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [ain_pkg::SAMPLE_BITS-1:0]   value,
    output logic                                     last_of_channel,
    output logic                                     last_of_tensor,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [ain_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [ain_pkg::CFG_DATA_W-1:0]           cfg_data
);

    ain_pkg::cmd_t              cmd;
    ain_pkg::status_t           stat;
    logic                       in_accept;
    logic                       mode_reg;
    logic [ain_pkg::LEN_W-1:0]  length_reg;
    logic [ain_pkg::CNT_W-1:0]  count_reg;
    logic [ain_pkg::EPS_W-1:0]  eps_reg;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && !in_stall;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            length_reg <= ain_pkg::LEN_W'(64);
            count_reg  <= ain_pkg::CNT_W'(1);
            eps_reg    <= ain_pkg::EPS_W'(168);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ain_pkg::CFG_MODE:    mode_reg   <= cfg_data[0];
                ain_pkg::CFG_LENGTH:  length_reg <= cfg_data[ain_pkg::LEN_W-1:0];
                ain_pkg::CFG_COUNT:   count_reg  <= cfg_data[ain_pkg::CNT_W-1:0];
                ain_pkg::CFG_EPSILON: eps_reg    <= cfg_data[ain_pkg::EPS_W-1:0];
                default:              mode_reg   <= mode_reg;
            endcase
        end
    end

    ain_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    ain_dp #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_accept       (in_accept),
        .sample          (sample),
        .style_scale     (style_scale),
        .style_shift     (style_shift),
        .mode            (mode_reg),
        .length          (length_reg),
        .count           (count_reg),
        .epsilon         (eps_reg),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .value           (value),
        .last_of_channel (last_of_channel),
        .last_of_tensor  (last_of_tensor)
    );

endmodule

FILE: rtl/ain_checker.sv
module ain_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_stall,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [ain_pkg::SAMPLE_BITS-1:0] value,
    input logic                                   last_of_channel,
    input logic                                   last_of_tensor
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value))
        else $error("output word changed under stall");

    // End of tensor only on end of channel
    a_tensor_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_tensor |-> last_of_channel)
        else $error("tensor mark without channel mark");

    // No input taken while a channel is still being emitted
    a_no_load_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_channel |-> in_stall)
        else $error("input taken during emit");

endmodule

bind adaptive_instance_normalization ain_checker u_ain_checker (.*);
